### sv/rce_pkg.sv
// shared constants and types for the ray/circle edge point core
// no dependencies; used by rce_front, rce_back, the top and the testbench
package rce_pkg;

    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 16;
    localparam int RADIUS_BITS = 10;
    localparam int OUT_BITS    = 14;
    localparam int QUEUE_DEPTH = 4;

    // classification of one item by its direction vector
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_VERT = 2'd1,
        KIND_GEN  = 2'd2
    } kind_t;

endpackage

### sv/rce_front.sv
// front end: input register, direction vector and item classification
// depends on rce_pkg
module rce_front #(
    parameter int COORD_BITS = rce_pkg::COORD_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // center_x, center_y, radius, cursor_x, cursor_y, zero pad
    input  logic [((4*COORD_BITS+rce_pkg::RADIUS_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                push_valid,
    input  logic                                push_ready,
    output logic [4*COORD_BITS+rce_pkg::RADIUS_BITS+3:0] push_data
);

    localparam int CB     = COORD_BITS;
    localparam int RB     = rce_pkg::RADIUS_BITS;
    localparam int ITEM_W = 4*CB + RB + 4;

    logic [CB-1:0]      cx;
    logic [CB-1:0]      cy;
    logic [RB-1:0]      rad;
    logic [CB-1:0]      ux;
    logic [CB-1:0]      uy;
    logic signed [CB:0] dx;
    logic signed [CB:0] dy;
    rce_pkg::kind_t     kind;
    logic [ITEM_W-1:0]  item_next;
    logic [ITEM_W-1:0]  item_reg;
    logic               vld_reg;

    // field unpack
    assign cx  = s_tdata[CB-1:0];
    assign cy  = s_tdata[2*CB-1:CB];
    assign rad = s_tdata[2*CB+RB-1:2*CB];
    assign ux  = s_tdata[3*CB+RB-1:2*CB+RB];
    assign uy  = s_tdata[4*CB+RB-1:3*CB+RB];

    // direction vector and classification
    always_comb
    begin
        dx = $signed({1'b0, ux}) - $signed({1'b0, cx});
        dy = $signed({1'b0, uy}) - $signed({1'b0, cy});
        if (dx == '0 && dy == '0)
        begin
            kind = rce_pkg::KIND_NONE;
        end
        else if (dx == '0)
        begin
            kind = rce_pkg::KIND_VERT;
        end
        else
        begin
            kind = rce_pkg::KIND_GEN;
        end
        item_next = {kind, dy, dx, rad, cy, cx};
    end

    // one register stage, refilled as soon as the queue takes it
    assign s_tready   = !vld_reg || push_ready;
    assign push_valid = vld_reg;
    assign push_data  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### sv/rce_fifo.sv
// short flop-based queue between the front end and the back end
// depends on nothing but its parameters
module rce_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [0:DEPTH-1];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/rce_sqrt.sv
// pipelined digit-by-digit square root, one root bit per stage
// depends on nothing but its parameters
module rce_sqrt #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [2*(COORD_BITS+1)-1:0]            s_in,
    output logic [COORD_BITS+1+FRAC_BITS-1:0]      root_out
);

    localparam int SP = COORD_BITS + 1;
    localparam int T  = SP + FRAC_BITS;
    localparam int SW = 2 * SP;

    logic [SW-1:0] s_pipe    [0:SP-1];
    logic [T-1:0]  rem_pipe  [0:T-1];
    logic [T-1:0]  root_pipe [0:T];

    assign s_pipe[0]    = s_in;
    assign rem_pipe[0]  = '0;
    assign root_pipe[0] = '0;
    assign root_out     = root_pipe[T];

    for (genvar i = 0; i < T; i++)
    begin : g_stage
        localparam int P = T - 1 - i;
        logic [1:0]   bits;
        logic [T+1:0] rem_sh;
        logic [T+1:0] trial;
        logic         ge;

        // next pair of radicand bits, zero once into the fraction
        if (P >= FRAC_BITS)
        begin : g_bits
            assign bits = s_pipe[i][2*(P-FRAC_BITS)+1 -: 2];
        end
        else
        begin : g_zero
            assign bits = 2'b00;
        end

        assign rem_sh = {rem_pipe[i], bits};
        assign trial  = {root_pipe[i], 2'b01};
        assign ge     = (rem_sh >= trial);

        // root bit decision
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_pipe[i+1] <= {root_pipe[i][T-2:0], ge};
            end
        end

        if (i < T - 1)
        begin : g_rem
            logic [T+1:0] diff;
            assign diff = rem_sh - trial;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_pipe[i+1] <= ge ? diff[T-1:0] : rem_sh[T-1:0];
                end
            end
        end

        if (i < SP - 1)
        begin : g_s
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    s_pipe[i+1] <= s_pipe[i];
                end
            end
        end
    end

endmodule

### sv/rce_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on nothing but its parameters; quotient must fit in QW bits
module rce_div #(
    parameter int NW = 38,
    parameter int DW = 29,
    parameter int QW = 27
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num_in,
    input  logic [DW-1:0] den_in,
    output logic [QW-1:0] quo_out
);

    logic [DW-1:0] rem_pipe [0:QW-1];
    logic [DW-1:0] den_pipe [0:QW-1];
    logic [QW-1:0] low_pipe [0:QW-1];
    logic [QW-1:0] q_pipe   [0:QW];

    // upper numerator bits seed the remainder, the rest shift in one per stage
    assign rem_pipe[0] = {{(DW-(NW-QW)){1'b0}}, num_in[NW-1:QW]};
    assign den_pipe[0] = den_in;
    assign low_pipe[0] = num_in[QW-1:0];
    assign q_pipe[0]   = '0;
    assign quo_out     = q_pipe[QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [DW:0] rem_sh;
        logic [DW:0] diff;
        logic        ge;

        assign rem_sh = {rem_pipe[i], low_pipe[i][QW-1-i]};
        assign diff   = rem_sh - {1'b0, den_pipe[i]};
        assign ge     = (rem_sh >= {1'b0, den_pipe[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_pipe[i+1] <= {q_pipe[i][QW-2:0], ge};
            end
        end

        if (i < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_pipe[i+1] <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
                    den_pipe[i+1] <= den_pipe[i];
                    low_pipe[i+1] <= low_pipe[i];
                end
            end
        end
    end

endmodule

### sv/rce_back.sv
// back end: squares, length root, offset divides and output register
// depends on rce_pkg, rce_sqrt and rce_div
module rce_back #(
    parameter int COORD_BITS = rce_pkg::COORD_BITS,
    parameter int FRAC_BITS  = rce_pkg::FRAC_BITS
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          pop_valid,
    output logic                                          pop_ready,
    input  logic [4*COORD_BITS+rce_pkg::RADIUS_BITS+3:0]  pop_data,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // point_x, point_y, zero pad
    output logic [((2*rce_pkg::OUT_BITS+7)/8)*8-1:0]      m_tdata,
    // valid_res
    output logic                                          m_tuser
);

    localparam int CB    = COORD_BITS;
    localparam int FB    = FRAC_BITS;
    localparam int RB    = rce_pkg::RADIUS_BITS;
    localparam int OB    = rce_pkg::OUT_BITS;
    localparam int OUT_W = ((2*OB+7)/8)*8;
    localparam int T     = CB + 1 + FB;
    localparam int QW    = RB + FB + 1;
    localparam int MW    = RB + CB;
    localparam int NW    = MW + FB;
    localparam int SBW   = 4 + RB + 2*CB;
    localparam int L     = T + QW;
    localparam int VW    = ((CB > RB + 1) ? CB : RB + 1) + FB + 4;

    // item fields from the queue head
    logic [CB-1:0]      cx;
    logic [CB-1:0]      cy;
    logic [RB-1:0]      rad;
    logic signed [CB:0] dx;
    logic signed [CB:0] dy;
    logic [1:0]         kind_bits;
    logic signed [CB:0] neg_x;
    logic signed [CB:0] neg_y;
    logic [CB-1:0]      mag_x;
    logic [CB-1:0]      mag_y;
    logic               en;

    // stage a: squares and radius products
    logic               vld_a_reg;
    logic [2*CB-1:0]    sq_x_reg;
    logic [2*CB-1:0]    sq_y_reg;
    logic [2*MW-1:0]    num_a_reg;
    logic [SBW-1:0]     sb_a_reg;

    // stage b onward
    logic [2*CB:0]      s_reg;
    logic               vld_pipe [0:L];
    logic [SBW-1:0]     sb_pipe  [0:L];
    logic [2*MW-1:0]    num_pipe [0:T];
    logic [T-1:0]       lq;
    logic [QW-1:0]      off_x;
    logic [QW-1:0]      off_y;

    // final stage
    logic [SBW-1:0]     sb_f;
    rce_pkg::kind_t     kind_f;
    logic               sgn_xf;
    logic               sgn_yf;
    logic [RB-1:0]      rad_f;
    logic [CB-1:0]      cy_f;
    logic [CB-1:0]      cx_f;
    logic signed [VW-1:0] vert_y;
    logic [OB-1:0]      px_next;
    logic [OB-1:0]      py_next;
    logic               vres_next;
    logic [OB-1:0]      px_reg;
    logic [OB-1:0]      py_reg;
    logic               vres_reg;
    logic               out_vld_reg;

    // centre plus signed offset, truncated toward zero and wrapped to the port
    function automatic logic [OB-1:0] place(input logic [CB-1:0] c,
                                            input logic [QW-1:0] off,
                                            input logic neg);
        logic signed [VW-1:0] cs;
        logic signed [VW-1:0] os;
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] vm;
        logic signed [VW-1:0] sh;
        logic signed [VW-1:0] res;
        cs  = $signed({{(VW-CB-FB){1'b0}}, c, {FB{1'b0}}});
        os  = $signed({{(VW-QW){1'b0}}, off});
        v   = neg ? cs - os : cs + os;
        vm  = v[VW-1] ? -v : v;
        sh  = vm >>> FB;
        res = v[VW-1] ? -sh : sh;
        return res[OB-1:0];
    endfunction

    assign en        = !out_vld_reg || m_tready;
    assign pop_ready = en;

    // unpack queue head
    assign cx        = pop_data[CB-1:0];
    assign cy        = pop_data[2*CB-1:CB];
    assign rad       = pop_data[2*CB+RB-1:2*CB];
    assign dx        = $signed(pop_data[3*CB+RB:2*CB+RB]);
    assign dy        = $signed(pop_data[4*CB+RB+1:3*CB+RB+1]);
    assign kind_bits = pop_data[4*CB+RB+3:4*CB+RB+2];
    assign neg_x     = -dx;
    assign neg_y     = -dy;
    assign mag_x     = dx[CB] ? neg_x[CB-1:0] : dx[CB-1:0];
    assign mag_y     = dy[CB] ? neg_y[CB-1:0] : dy[CB-1:0];

    // valid tracking through the whole back pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            for (int k = 0; k <= L; k++)
            begin
                vld_pipe[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_a_reg   <= pop_valid;
            vld_pipe[0] <= vld_a_reg;
            for (int k = 1; k <= L; k++)
            begin
                vld_pipe[k] <= vld_pipe[k-1];
            end
        end
    end

    // stage a and stage b payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x_reg    <= (2*CB)'(mag_x) * (2*CB)'(mag_x);
            sq_y_reg    <= (2*CB)'(mag_y) * (2*CB)'(mag_y);
            num_a_reg   <= {MW'(rad) * MW'(mag_y), MW'(rad) * MW'(mag_x)};
            sb_a_reg    <= {kind_bits, dy[CB], dx[CB], rad, cy, cx};
            s_reg       <= {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
            num_pipe[0] <= num_a_reg;
            sb_pipe[0]  <= sb_a_reg;
        end
    end

    // side information follows the root and divide stages
    for (genvar k = 1; k <= L; k++)
    begin : g_sb
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sb_pipe[k] <= sb_pipe[k-1];
            end
        end
    end

    for (genvar k = 1; k <= T; k++)
    begin : g_num
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_pipe[k] <= num_pipe[k-1];
            end
        end
    end

    // vector length with FRAC_BITS fraction bits
    rce_sqrt #(
        .COORD_BITS (CB),
        .FRAC_BITS  (FB)
    ) u_sqrt (
        .clk      (clk),
        .en       (en),
        .s_in     ({1'b0, s_reg}),
        .root_out (lq)
    );

    // scaled offsets along x and y
    rce_div #(
        .NW (NW),
        .DW (T),
        .QW (QW)
    ) u_div_x (
        .clk     (clk),
        .en      (en),
        .num_in  ({num_pipe[T][MW-1:0], {FB{1'b0}}}),
        .den_in  (lq),
        .quo_out (off_x)
    );

    rce_div #(
        .NW (NW),
        .DW (T),
        .QW (QW)
    ) u_div_y (
        .clk     (clk),
        .en      (en),
        .num_in  ({num_pipe[T][2*MW-1:MW], {FB{1'b0}}}),
        .den_in  (lq),
        .quo_out (off_y)
    );

    // result selection by item kind
    assign sb_f   = sb_pipe[L];
    assign cx_f   = sb_f[CB-1:0];
    assign cy_f   = sb_f[2*CB-1:CB];
    assign rad_f  = sb_f[2*CB+RB-1:2*CB];
    assign sgn_xf = sb_f[2*CB+RB];
    assign sgn_yf = sb_f[2*CB+RB+1];
    assign kind_f = rce_pkg::kind_t'(sb_f[SBW-1:SBW-2]);

    always_comb
    begin
        vert_y = sgn_yf ? $signed({{(VW-CB){1'b0}}, cy_f}) - $signed({{(VW-RB){1'b0}}, rad_f})
                        : $signed({{(VW-CB){1'b0}}, cy_f}) + $signed({{(VW-RB){1'b0}}, rad_f});
        case (kind_f)
            rce_pkg::KIND_VERT:
            begin
                px_next   = OB'(cx_f);
                py_next   = vert_y[OB-1:0];
                vres_next = 1'b1;
            end
            rce_pkg::KIND_GEN:
            begin
                px_next   = place(cx_f, off_x, sgn_xf);
                py_next   = place(cy_f, off_y, sgn_yf);
                vres_next = 1'b1;
            end
            default:
            begin
                px_next   = '0;
                py_next   = '0;
                vres_next = 1'b0;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_pipe[L];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            vres_reg <= vres_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OUT_W-2*OB){1'b0}}, py_reg, px_reg};
    assign m_tuser  = vres_reg;

    // a coincident item always reports the origin
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !vres_reg |-> px_reg == '0 && py_reg == '0)
        else $error("coincident result not zero");

    // an item leaving the last stage lands in the output register
    a_last_lands: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_pipe[L] |=> out_vld_reg)
        else $error("result lost at output register");

    // a stalled output freezes the pipeline head and tail
    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_pipe[L]) && $stable(vld_a_reg))
        else $error("pipeline moved during stall");

endmodule

### sv/ray_circle_edge_point_core.sv
// throughput: one item per cycle while the output is taken; the queue absorbs
// short output stalls while the front keeps accepting
// the root and divide stages are fully pipelined, one bit per stage
// reset: rst_n asynchronous, clears every valid flag and the queue
module ray_circle_edge_point_core #(
    parameter int COORD_BITS = rce_pkg::COORD_BITS,
    parameter int FRAC_BITS  = rce_pkg::FRAC_BITS
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    s_tvalid,
    output logic                                                    s_tready,
    // center_x, center_y, radius, cursor_x, cursor_y, zero pad
    input  logic [((4*COORD_BITS+rce_pkg::RADIUS_BITS+7)/8)*8-1:0]  s_tdata,
    output logic                                                    m_tvalid,
    input  logic                                                    m_tready,
    // point_x, point_y, zero pad
    output logic [((2*rce_pkg::OUT_BITS+7)/8)*8-1:0]                m_tdata,
    // valid_res
    output logic                                                    m_tuser
);

    localparam int ITEM_W = 4*COORD_BITS + rce_pkg::RADIUS_BITS + 4;

    logic              push_valid;
    logic              push_ready;
    logic [ITEM_W-1:0] push_data;
    logic              pop_valid;
    logic              pop_ready;
    logic [ITEM_W-1:0] pop_data;

    // accept and classify
    rce_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    rce_fifo #(
        .W     (ITEM_W),
        .DEPTH (rce_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // compute the edge point
    rce_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### dv/tb.sv
// testbench for ray_circle_edge_point_core: random and directed ray/circle items
// depends on rce_pkg and the core; self-checking against an in-bench predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS  = rce_pkg::COORD_BITS;
    localparam int FRAC_BITS   = rce_pkg::FRAC_BITS;
    localparam int RADIUS_BITS = rce_pkg::RADIUS_BITS;
    localparam int OUT_BITS    = rce_pkg::OUT_BITS;
    localparam int IN_W  = ((4*COORD_BITS+RADIUS_BITS+7)/8)*8;
    localparam int OUT_W = ((2*OUT_BITS+7)/8)*8;
    localparam int LATENCY = 4 + (COORD_BITS+1+FRAC_BITS) + (11+FRAC_BITS);
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [COORD_BITS-1:0]  cur_y;
        logic [COORD_BITS-1:0]  cur_x;
        logic [RADIUS_BITS-1:0] rad;
        logic [COORD_BITS-1:0]  cen_y;
        logic [COORD_BITS-1:0]  cen_x;
    } ray_item_t;

    typedef struct packed {
        logic                       hit;
        logic signed [OUT_BITS-1:0] py;
        logic signed [OUT_BITS-1:0] px;
    } edge_point_t;

    logic clk, rst_n;
    logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
    logic [IN_W-1:0]  s_tdata;
    logic [OUT_W-1:0] m_tdata;

    ray_item_t   pending_items[$];
    edge_point_t expected_points[$];
    int  errors = 0;
    int  gap_left = 0, stall_left = 0;
    bit  hold_off = 0;   // long receiver stall request
    longint cycles = 0;

    ray_circle_edge_point_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // bitwise square root with FRAC_BITS fraction bits, floored
    function automatic longint unsigned root_frac(longint unsigned s);
        longint unsigned rem, root, trial, bits;
        int total, p;
        rem = 0;
        root = 0;
        total = COORD_BITS + 1 + FRAC_BITS;
        for (int i = 0; i < total; i++)
        begin
            p = total - 1 - i;
            bits = (p >= FRAC_BITS) ? ((s >> (2*(p-FRAC_BITS))) & 3) : 0;
            rem = (rem << 2) | bits;
            trial = (root << 2) | 1;
            if (rem >= trial)
            begin
                rem -= trial;
                root = (root << 1) | 1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    // centre plus scaled offset, truncated toward zero
    function automatic longint edge_coord(longint c, longint delta, longint unsigned r,
                                          longint unsigned len);
        longint unsigned mag;
        longint off, v;
        mag = (delta < 0) ? -delta : delta;
        off = ((r * mag) << FRAC_BITS) / len;
        v = c * (longint'(1) << FRAC_BITS) + ((delta < 0) ? -off : off);
        if (v >= 0)
            return v >>> FRAC_BITS;
        return -((-v) >>> FRAC_BITS);
    endfunction

    function automatic edge_point_t predict_edge(ray_item_t it);
        edge_point_t p;
        longint cx, cy, dx, dy, px, py;
        longint unsigned r, len;
        cx = longint'(it.cen_x);
        cy = longint'(it.cen_y);
        r  = 64'(it.rad);
        dx = longint'(it.cur_x) - cx;
        dy = longint'(it.cur_y) - cy;
        p = '0;
        if (dx == 0 && dy == 0)
            return p;
        if (dx == 0)
        begin
            px = cx;
            py = (dy > 0) ? cy + longint'(r) : cy - longint'(r);
        end
        else
        begin
            len = root_frac(dx*dx + dy*dy);
            px = edge_coord(cx, dx, r, len);
            py = edge_coord(cy, dy, r, len);
        end
        p.px = px[OUT_BITS-1:0];
        p.py = py[OUT_BITS-1:0];
        p.hit = 1'b1;
        return p;
    endfunction

    function automatic ray_item_t make_item(int cx, int cy, int r, int ux, int uy);
        ray_item_t it;
        it.cen_x = COORD_BITS'(cx);
        it.cen_y = COORD_BITS'(cy);
        it.rad   = RADIUS_BITS'(r);
        it.cur_x = COORD_BITS'(ux);
        it.cur_y = COORD_BITS'(uy);
        return it;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic int rand_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    // clock
    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                expected_points.push_back(predict_edge(ray_item_t'(s_tdata[$bits(ray_item_t)-1:0])));
            if (gap_left > 0 || pending_items.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= IN_W'(pending_items.pop_front());
                gap_left <= ($urandom_range(0, 2) == 0) ? rand_gap() : 0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        edge_point_t got, want;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (m_tvalid && m_tready)
            begin
                got.px = m_tdata[OUT_BITS-1:0];
                got.py = m_tdata[2*OUT_BITS-1:OUT_BITS];
                got.hit = m_tuser;
                if (expected_points.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected transaction px=%0d py=%0d valid=%0b",
                             $time, got.px, got.py, got.hit);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.px !== want.px)
                    begin
                        errors++;
                        $display("%0t point_x expected %0d actual %0d", $time, want.px, got.px);
                    end
                    if (got.py !== want.py)
                    begin
                        errors++;
                        $display("%0t point_y expected %0d actual %0d", $time, want.py, got.py);
                    end
                    if (got.hit !== want.hit)
                    begin
                        errors++;
                        $display("%0t valid_res expected %0b actual %0b", $time, want.hit, got.hit);
                    end
                end
            end
            if (hold_off)
                m_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left <= rand_gap();
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
    end

    // watchdog
    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        int cx, cy;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n = 1'b1;

        // directed: coincident, vertical both ways, horizontal, corners, radius extremes
        pending_items.push_back(make_item(100, 100, 50, 100, 100));
        pending_items.push_back(make_item(0, 0, 0, 0, 0));
        pending_items.push_back(make_item(4095, 4095, 1023, 4095, 4095));
        pending_items.push_back(make_item(200, 200, 30, 200, 900));
        pending_items.push_back(make_item(200, 200, 30, 200, 0));
        pending_items.push_back(make_item(0, 0, 1023, 0, 4095));
        pending_items.push_back(make_item(4095, 4095, 1023, 4095, 0));
        pending_items.push_back(make_item(0, 10, 1023, 0, 0));
        pending_items.push_back(make_item(500, 500, 100, 4095, 500));
        pending_items.push_back(make_item(500, 500, 100, 0, 500));
        pending_items.push_back(make_item(0, 0, 1023, 4095, 4095));
        pending_items.push_back(make_item(4095, 4095, 1023, 0, 0));
        pending_items.push_back(make_item(0, 4095, 1023, 4095, 0));
        pending_items.push_back(make_item(4095, 0, 1023, 0, 4095));
        pending_items.push_back(make_item(10, 10, 1023, 11, 10));
        pending_items.push_back(make_item(10, 10, 1023, 9, 9));
        pending_items.push_back(make_item(2048, 2048, 0, 3000, 1000));
        pending_items.push_back(make_item(1, 1, 1, 4095, 2));
        pending_items.push_back(make_item(2730, 1365, 682, 1365, 2730));

        // random, with near-centre, vertical and coincident cases mixed in
        for (int i = 0; i < 400; i++)
        begin
            if (i == 200)
            begin
                // sender pause until every result has come
                wait (pending_items.size() == 0 && !s_tvalid && expected_points.size() == 0);
            end
            cx = rand_coord();
            cy = rand_coord();
            case ($urandom_range(0, 9))
                0: pending_items.push_back(make_item(cx, cy, $urandom_range(0, 1023), cx, cy));
                1: pending_items.push_back(make_item(cx, cy, $urandom_range(0, 1023),
                                                     cx, rand_coord()));
                2: pending_items.push_back(make_item(cx, cy, $urandom_range(0, 1023),
                                                     (cx + $urandom_range(0, 6)) % 4096,
                                                     (cy + $urandom_range(0, 6)) % 4096));
                3: pending_items.push_back(make_item(cx, cy, $urandom_range(0, 1) ? 1023 : 0,
                                                     rand_coord(), rand_coord()));
                default: pending_items.push_back(make_item(cx, cy, $urandom_range(0, 1023),
                                                           rand_coord(), rand_coord()));
            endcase
        end

        wait (pending_items.size() == 0 && !s_tvalid && expected_points.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
